FILE: rtl/fit_pkg.sv
// ----------------------------------------------------------------------------
// fit_pkg
// Shared types, constants and the elaboration-time Gaussian curve function.
// ----------------------------------------------------------------------------
package fit_pkg;

    localparam int TEMP_W  = 11;
    localparam int HUM_W   = 10;
    localparam int HOURS_W = 11;
    localparam int X_W     = 12;
    localparam int QUO_W   = 11;
    localparam int SPAN_W  = 8;

    typedef enum logic [1:0] {
        MODE_ZERO,
        MODE_FLAT,
        MODE_RISE,
        MODE_FALL
    } mode_t;

    // exp(-d*d/5000) scaled to 2^(deg_bits-1); constant use only
    function automatic logic [63:0] gauss_entry(input int offset, input int deg_bits);
        logic [63:0] sq;
        logic [63:0] t;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] one;
        sq   = 64'(offset) * 64'(offset);
        one  = 64'd1 << 30;
        term = one;
        sum  = one;
        t    = (sq << 30) / 64'd160000;
        for (int n = 1; n <= 10; n++) begin
            term = ((term * t) >> 30) / 64'(n);
            if ((n % 2) == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        for (int k = 0; k < 5; k++) begin
            sum = (sum * sum) >> 30;
        end
        if (sq >= 64'd85000) begin
            return 64'd0;
        end
        return (sum * (64'd1 << (deg_bits - 1)) + (64'd1 << 29)) >> 30;
    endfunction

endpackage

FILE: rtl/fuzzy_irrigation_time.sv
// ----------------------------------------------------------------------------
// fuzzy_irrigation_time
// Fuzzy irrigation-time estimator: trapezoid/Gaussian fuzzification, min/max
// rules, weighted-average defuzzification.
// ----------------------------------------------------------------------------
// Fully pipelined: one reading per clock while not stalled, registered through
// 3 fuzzification stages, 1 rule stage, 1 sum stage and 11 divider stages (one
// quotient bit each). The whole pipeline advances when the output register is
// empty or taken; a stall holds every stage. Output is in 1/256 units.
module fuzzy_irrigation_time #(
    parameter int GAUSS_TABLE_DEPTH = 512,
    parameter int DEGREE_BITS       = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // temperature[10:0], air_humidity[20:11], soil_humidity[30:21], hours_since[41:31]
    input  logic [47:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // irrigation_time[10:0]
    output logic [15:0] m_axis_tdata
);

    localparam int DB    = DEGREE_BITS;
    localparam int GW    = $clog2(GAUSS_TABLE_DEPTH);
    localparam int XW    = fit_pkg::X_W;
    localparam int NUM_W = DB + 12;
    localparam int DEN_W = DB + 3;

    logic en;
    logic [3:1] v_reg;
    logic       v4_reg;
    logic       v5_reg;

    logic signed [XW-1:0] temp_c, air_c, soil_c, hrs_c;
    logic signed [XW-1:0] t_in, a_in, s_in, h_in;

    logic [DB-1:0] t_opt, t_high, a_low, a_opt, s_dry, s_opt, s_wet, h_recent, h_long;

    logic [DB-1:0] gauss_rom [GAUSS_TABLE_DEPTH];
    logic [fit_pkg::HOURS_W-1:0] hour_dist;
    logic [GW-1:0] gidx;
    logic [DB-1:0] g1_reg, g2_reg, g3_reg;
    logic          far1_reg, far2_reg, far3_reg;
    logic [DB-1:0] h_opt;

    logic [DB-1:0] closed_reg, few_reg, med_reg;
    logic [DB-1:0] closed_next, few_next, med_next;
    logic [NUM_W-1:0] num_reg;
    logic [DEN_W-1:0] den_reg;
    logic [DB+1:0]    dsum;

    logic                      out_valid;
    logic [fit_pkg::QUO_W-1:0] quo;

    function automatic logic [DB-1:0] mn(input logic [DB-1:0] a, input logic [DB-1:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic [DB-1:0] mx(input logic [DB-1:0] a, input logic [DB-1:0] b);
        return (a > b) ? a : b;
    endfunction

    assign en            = !out_valid || m_axis_tready;
    assign s_axis_tready = en;

    always_comb begin
        t_in = XW'(signed'(s_axis_tdata[10:0]));
        a_in = XW'(s_axis_tdata[20:11]);
        s_in = XW'(s_axis_tdata[30:21]);
        h_in = XW'(s_axis_tdata[41:31]);
        temp_c = (t_in < -XW'(400)) ? -XW'(400) : ((t_in > XW'(800)) ? XW'(800) : t_in);
        air_c  = (a_in > XW'(1000)) ? XW'(1000) : a_in;
        soil_c = (s_in > XW'(1000)) ? XW'(1000) : s_in;
        hrs_c  = (h_in > XW'(2000)) ? XW'(2000) : h_in;
        hour_dist = (hrs_c >= XW'(200)) ? fit_pkg::HOURS_W'(hrs_c - XW'(200))
                                        : fit_pkg::HOURS_W'(XW'(200) - hrs_c);
        gidx   = GW'(hour_dist);
    end

    fit_trap #(.A(150), .B(200), .C(300),  .D(350),  .DB(DB)) u_t_opt
        (.aclk(aclk), .en(en), .x(temp_c), .deg(t_opt));
    fit_trap #(.A(300), .B(400), .C(500),  .D(500),  .DB(DB)) u_t_high
        (.aclk(aclk), .en(en), .x(temp_c), .deg(t_high));
    fit_trap #(.A(0),   .B(0),   .C(200),  .D(350),  .DB(DB)) u_a_low
        (.aclk(aclk), .en(en), .x(air_c), .deg(a_low));
    fit_trap #(.A(300), .B(400), .C(600),  .D(700),  .DB(DB)) u_a_opt
        (.aclk(aclk), .en(en), .x(air_c), .deg(a_opt));
    fit_trap #(.A(0),   .B(0),   .C(300),  .D(400),  .DB(DB)) u_s_dry
        (.aclk(aclk), .en(en), .x(soil_c), .deg(s_dry));
    fit_trap #(.A(300), .B(400), .C(600),  .D(700),  .DB(DB)) u_s_opt
        (.aclk(aclk), .en(en), .x(soil_c), .deg(s_opt));
    fit_trap #(.A(700), .B(800), .C(1000), .D(1000), .DB(DB)) u_s_wet
        (.aclk(aclk), .en(en), .x(soil_c), .deg(s_wet));
    fit_trap #(.A(0),   .B(0),   .C(120),  .D(220),  .DB(DB)) u_h_recent
        (.aclk(aclk), .en(en), .x(hrs_c), .deg(h_recent));
    fit_trap #(.A(260), .B(400), .C(500),  .D(500),  .DB(DB)) u_h_long
        (.aclk(aclk), .en(en), .x(hrs_c), .deg(h_long));

    for (genvar i = 0; i < GAUSS_TABLE_DEPTH; i++) begin : g_rom
        assign gauss_rom[i] = DB'(fit_pkg::gauss_entry(i, DB));
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            g1_reg   <= gauss_rom[gidx];
            far1_reg <= (32'(hour_dist) >= GAUSS_TABLE_DEPTH);
            g2_reg   <= g1_reg;
            far2_reg <= far1_reg;
            g3_reg   <= g2_reg;
            far3_reg <= far2_reg;
        end
    end

    always_comb begin
        h_opt       = far3_reg ? '0 : g3_reg;
        closed_next = mx(h_recent, mx(s_opt, s_wet));
        few_next    = mx(mn(h_opt, s_dry),
                         mx(mn(mn(h_long, s_opt), mn(t_high, a_low)),
                            mn(mn(h_opt, s_dry), mn(t_opt, a_opt))));
        med_next    = mx(mn(h_long, s_dry),
                         mn(mn(h_opt, s_dry), mn(t_high, a_low)));
        dsum        = (DB+2)'(closed_reg) + (DB+2)'(few_reg) + (DB+2)'(med_reg);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            closed_reg <= closed_next;
            few_reg    <= few_next;
            med_reg    <= med_next;
            num_reg    <= (NUM_W'(few_reg) << 11) + (NUM_W'(med_reg) << 12)
                        + (NUM_W'(med_reg) << 9);
            den_reg    <= DEN_W'(dsum) + (DEN_W'(dsum) << 1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg  <= '0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else if (en) begin
            v_reg  <= {v_reg[2:1], s_axis_tvalid};
            v4_reg <= v_reg[3];
            v5_reg <= v4_reg;
        end
    end

    fit_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v5_reg),
        .num       (num_reg),
        .den       (den_reg),
        .out_valid (out_valid),
        .quo       (quo)
    );

    assign m_axis_tvalid = out_valid;
    assign m_axis_tdata  = {5'd0, quo};

endmodule

FILE: rtl/fit_trap.sv
// ----------------------------------------------------------------------------
// fit_trap
// Three-stage trapezoid membership: segment select, reciprocal multiply,
// remainder correction.
// ----------------------------------------------------------------------------
module fit_trap #(
    parameter int A  = 0,
    parameter int B  = 0,
    parameter int C  = 0,
    parameter int D  = 0,
    parameter int DB = 16
) (
    input  logic                            aclk,
    input  logic                            en,
    input  logic signed [fit_pkg::X_W-1:0]  x,
    output logic [DB-1:0]                   deg
);

    localparam int S    = DB + 8;
    localparam int V_W  = fit_pkg::SPAN_W + DB - 1;
    localparam int RS   = (B > A) ? (B - A) : 1;
    localparam int FS   = (D > C) ? (D - C) : 1;
    localparam logic [S-1:0] RR = S'((64'd1 << S) / 64'(RS));
    localparam logic [S-1:0] FR = S'((64'd1 << S) / 64'(FS));
    localparam logic [DB-1:0] ONE = DB'(1) << (DB - 1);

    fit_pkg::mode_t              mode1_reg, mode2_reg;
    fit_pkg::mode_t              mode_next;
    logic [fit_pkg::SPAN_W-1:0]  d1_reg, d2_reg, d_next;
    logic [DB-1:0]               q2_reg, q_next;
    logic [DB-1:0]               deg_reg, deg_next;

    logic signed [fit_pkg::X_W:0] xs, diff_r, diff_f;
    logic [V_W-1:0]               v1, v2;
    logic [V_W+S-1:0]             prod;
    logic [V_W:0]                 rem;
    logic [fit_pkg::SPAN_W-1:0]   span2;
    logic [DB-1:0]                qc;

    always_comb begin
        xs     = {x[fit_pkg::X_W-1], x};
        diff_r = xs - (fit_pkg::X_W+1)'(A);
        diff_f = (fit_pkg::X_W+1)'(D) - xs;
        if (xs <= (fit_pkg::X_W+1)'(A) || xs >= (fit_pkg::X_W+1)'(D)) begin
            mode_next = fit_pkg::MODE_ZERO;
            d_next    = '0;
        end else if (xs <= (fit_pkg::X_W+1)'(B)) begin
            mode_next = fit_pkg::MODE_RISE;
            d_next    = fit_pkg::SPAN_W'(diff_r);
        end else if (xs >= (fit_pkg::X_W+1)'(C)) begin
            mode_next = fit_pkg::MODE_FALL;
            d_next    = fit_pkg::SPAN_W'(diff_f);
        end else begin
            mode_next = fit_pkg::MODE_FLAT;
            d_next    = '0;
        end
    end

    always_comb begin
        v1     = {d1_reg, {(DB-1){1'b0}}};
        prod   = (V_W+S)'(v1) * (V_W+S)'((mode1_reg == fit_pkg::MODE_FALL) ? FR : RR);
        q_next = DB'(prod >> S);
    end

    always_comb begin
        v2    = {d2_reg, {(DB-1){1'b0}}};
        span2 = (mode2_reg == fit_pkg::MODE_FALL) ? fit_pkg::SPAN_W'(FS)
                                                  : fit_pkg::SPAN_W'(RS);
        rem   = (V_W+1)'(v2) - (V_W+1)'(q2_reg) * (V_W+1)'(span2);
        qc    = (rem >= (V_W+1)'(span2)) ? q2_reg + DB'(1) : q2_reg;
        unique case (mode2_reg)
            fit_pkg::MODE_ZERO: deg_next = '0;
            fit_pkg::MODE_FLAT: deg_next = ONE;
            default:            deg_next = qc;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mode1_reg <= mode_next;
            d1_reg    <= d_next;
            mode2_reg <= mode1_reg;
            d2_reg    <= d1_reg;
            q2_reg    <= q_next;
            deg_reg   <= deg_next;
        end
    end

    assign deg = deg_reg;

endmodule

FILE: rtl/fit_div.sv
// ----------------------------------------------------------------------------
// fit_div
// Pipelined restoring divider, one quotient bit per stage. Zero divisor
// yields zero.
// ----------------------------------------------------------------------------
module fit_div #(
    parameter int NUM_W = 28,
    parameter int DEN_W = 19
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic [NUM_W-1:0]          num,
    input  logic [DEN_W-1:0]          den,
    output logic                      out_valid,
    output logic [fit_pkg::QUO_W-1:0] quo
);

    localparam int QW = fit_pkg::QUO_W;
    localparam int CW = ((DEN_W + QW) > NUM_W) ? (DEN_W + QW) : NUM_W;

    logic [NUM_W-1:0] r_reg [QW];
    logic [DEN_W-1:0] d_reg [QW];
    logic [QW-1:0]    q_reg [QW];
    logic [QW-1:0]    v_reg;

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [NUM_W-1:0] r_in;
        logic [DEN_W-1:0] d_in;
        logic [QW-1:0]    q_in;
        logic             v_in;
        logic [CW-1:0]    dsh;
        logic             take;

        if (k == 0) begin : g_first
            assign r_in = num;
            assign d_in = den;
            assign q_in = '0;
            assign v_in = in_valid;
        end else begin : g_rest
            assign r_in = r_reg[k-1];
            assign d_in = d_reg[k-1];
            assign q_in = q_reg[k-1];
            assign v_in = v_reg[k-1];
        end

        assign dsh  = CW'(d_in) << (QW - 1 - k);
        assign take = (d_in != '0) && (CW'(r_in) >= dsh);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (en) begin
                v_reg[k] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                r_reg[k] <= take ? NUM_W'(CW'(r_in) - dsh) : r_in;
                d_reg[k] <= d_in;
                q_reg[k] <= q_in | (QW'(take) << (QW - 1 - k));
            end
        end
    end

    assign out_valid = v_reg[QW-1];
    assign quo       = q_reg[QW-1];

endmodule
